FILE: src/http_chunked_body_decoder_macros.svh
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/hcbd_pkg.sv
// Types, constants and helper functions of the chunked body decoder.
package hcbd_pkg;

	localparam int SIZE_BITS_DEF = 32;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;

	typedef enum logic [1:0] {
		ST_ZERO_CHUNK = 2'd0,
		ST_INPUT_END  = 2'd1,
		ST_BAD_LINE   = 2'd2,
		ST_TRUNCATED  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		PH_LEAD   = 5'b00001,
		PH_DIGITS = 5'b00010,
		PH_EXT    = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_SKIP   = 5'b10000
	} phase_t;

	// Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

	// Whitespace that may precede the size digits (CR is handled apart).
	function automatic logic is_lead_ws(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
			(b == CH_FF);
	endfunction

endpackage

FILE: src/http_chunked_body_decoder.sv
// Top level of the HTTP chunked transfer body decoder.
//
// This block takes a raw HTTP message body one byte per word on the slave stream and strips
// the chunked transfer framing. Each chunk opens with a size line (optional leading
// whitespace, hex digits, an optional ';' extension that is ignored, then CR LF); the chunk's
// payload bytes are then passed out on the master stream with has_data set, and the two bytes
// after the payload are skipped unchecked. Decoding stops at a zero-size chunk (status 0, on
// the LF of its line), at a malformed size line or a size that overflows SIZE_BITS bits
// (status 2, on the byte that proves it). After a stop, bytes are dropped until the word
// marked with tlast, which returns the block to its reset state for the next body. If the
// body ends before a stop, the word for the tlast byte carries the end mark with status 3
// when a chunk still lacks payload bytes, else status 1; payload already passed out is not
// taken back, and a last byte that is payload carries data and end mark in one word. The
// decode of one input byte (a hex shift-add, a decrement of the remaining count, a few
// compares) sits between the state registers and a one-deep output register, so one word
// is accepted per clock whenever the output register is empty or being drained in the same
// cycle. Bytes that cause no result produce no output word. The output word is registered
// and becomes valid in the cycle after its input byte is accepted.
module http_chunked_body_decoder #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // end_mark
	output logic [2:0] m_tuser    // [0] has_data, [2:1] end_status
);

	`include "http_chunked_body_decoder_macros.svh"

	// Decoder state.
	hcbd_pkg::phase_t     phase_q, phase_d;
	logic [SIZE_BITS-1:0] size_q, size_d;     // chunk size, then remaining payload bytes
	logic                 crp_q, crp_d;       // a CR was seen and waits for its LF
	logic                 skip_q, skip_d;     // first of the two trailing bytes consumed
	logic                 stop_q, stop_d;     // decoding ended, drop bytes until tlast

	// Output register.
	logic                 m_valid_q;
	logic [7:0]           m_byte_q;
	logic                 m_data_q;
	logic                 m_end_q;
	hcbd_pkg::status_t    m_status_q;

	// Per-byte decode results.
	logic                 in_accept;
	logic [4:0]           hex;
	logic                 line_done;
	logic                 res_data;
	logic                 res_end;
	hcbd_pkg::status_t    res_status;

	// The output register frees up when it is empty or drained this cycle.
	assign s_tready  = !m_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;
	assign hex       = hcbd_pkg::hex_decode(s_tdata);

	always_comb begin
		phase_d    = phase_q;
		size_d     = size_q;
		crp_d      = crp_q;
		skip_d     = skip_q;
		stop_d     = stop_q;
		line_done  = 1'b0;
		res_data   = 1'b0;
		res_end    = 1'b0;
		res_status = hcbd_pkg::ST_ZERO_CHUNK;

		if (!stop_q) begin
			unique case (phase_q)
				hcbd_pkg::PH_LEAD: begin
					if (crp_q && s_tdata == hcbd_pkg::CH_LF) begin
						// An empty line before any digit is malformed.
						res_end    = 1'b1;
						res_status = hcbd_pkg::ST_BAD_LINE;
					end else if (crp_q && s_tdata == hcbd_pkg::CH_CR) begin
						crp_d = 1'b1;
					end else begin
						// A CR not followed by LF counts as whitespace.
						crp_d = 1'b0;
						if (s_tdata == hcbd_pkg::CH_CR) begin
							crp_d = 1'b1;
						end else if (hex[4]) begin
							size_d  = {{(SIZE_BITS-4){1'b0}}, hex[3:0]};
							phase_d = hcbd_pkg::PH_DIGITS;
						end else if (!hcbd_pkg::is_lead_ws(s_tdata)) begin
							res_end    = 1'b1;
							res_status = hcbd_pkg::ST_BAD_LINE;
						end
					end
				end
				hcbd_pkg::PH_DIGITS: begin
					if (crp_q) begin
						if (s_tdata == hcbd_pkg::CH_LF) begin
							line_done = 1'b1;
						end else begin
							res_end    = 1'b1;
							res_status = hcbd_pkg::ST_BAD_LINE;
						end
					end else if (s_tdata == hcbd_pkg::CH_CR) begin
						crp_d = 1'b1;
					end else if (hex[4]) begin
						// A digit that would push the size past its width is an overflow.
						if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
							res_end    = 1'b1;
							res_status = hcbd_pkg::ST_BAD_LINE;
						end else begin
							size_d = {size_q[SIZE_BITS-5:0], hex[3:0]};
						end
					end else if (s_tdata == hcbd_pkg::CH_SEMI) begin
						phase_d = hcbd_pkg::PH_EXT;
					end else begin
						res_end    = 1'b1;
						res_status = hcbd_pkg::ST_BAD_LINE;
					end
				end
				hcbd_pkg::PH_EXT: begin
					// Extension text is ignored up to the CR LF.
					if (crp_q) begin
						if (s_tdata == hcbd_pkg::CH_LF) begin
							line_done = 1'b1;
						end else if (s_tdata != hcbd_pkg::CH_CR) begin
							crp_d = 1'b0;
						end
					end else if (s_tdata == hcbd_pkg::CH_CR) begin
						crp_d = 1'b1;
					end
				end
				hcbd_pkg::PH_DATA: begin
					res_data = 1'b1;
					size_d   = size_q - SIZE_BITS'(1);
					if (size_q == SIZE_BITS'(1)) begin
						phase_d = hcbd_pkg::PH_SKIP;
						skip_d  = 1'b0;
					end
				end
				hcbd_pkg::PH_SKIP: begin
					// Two bytes after the payload are dropped unchecked.
					if (skip_q) begin
						phase_d = hcbd_pkg::PH_LEAD;
						skip_d  = 1'b0;
						size_d  = '0;
						crp_d   = 1'b0;
					end else begin
						skip_d = 1'b1;
					end
				end
				default: begin
					phase_d = hcbd_pkg::PH_LEAD;
				end
			endcase

			if (line_done) begin
				crp_d = 1'b0;
				if (size_q == '0) begin
					res_end    = 1'b1;
					res_status = hcbd_pkg::ST_ZERO_CHUNK;
				end else begin
					phase_d = hcbd_pkg::PH_DATA;
				end
			end

			if (res_end) begin
				stop_d = 1'b1;
			end else if (s_tlast) begin
				res_end    = 1'b1;
				res_status = (phase_d == hcbd_pkg::PH_DATA && size_d != '0) ?
					hcbd_pkg::ST_TRUNCATED : hcbd_pkg::ST_INPUT_END;
			end
		end

		// The last byte of a body always returns the decoder to its reset state.
		if (s_tlast) begin
			phase_d = hcbd_pkg::PH_LEAD;
			size_d  = '0;
			crp_d   = 1'b0;
			skip_d  = 1'b0;
			stop_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_LEAD;
			size_q  <= '0;
			crp_q   <= 1'b0;
			skip_q  <= 1'b0;
			stop_q  <= 1'b0;
		end else if (in_accept) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			crp_q   <= crp_d;
			skip_q  <= skip_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_accept) begin
			m_valid_q <= res_data || res_end;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			m_byte_q   <= res_data ? s_tdata : 8'd0;
			m_data_q   <= res_data;
			m_end_q    <= res_end;
			m_status_q <= res_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tlast  = m_end_q;
	assign m_tuser  = {m_status_q, m_data_q};

	// A word without an end mark must be payload with a clear status.
	`HCBD_ASSERT_NOW(a_mid_word_is_data, m_valid_q && !m_end_q,
		m_data_q && m_status_q == hcbd_pkg::ST_ZERO_CHUNK, "non-end word without payload")

	// A chunk body is never entered with nothing left to pass out.
	`HCBD_ASSERT_NOW(a_data_count_nonzero, phase_q == hcbd_pkg::PH_DATA,
		size_q != '0, "payload phase with zero remaining count")

	// The last byte of a body leaves the decoder in its reset state.
	`HCBD_ASSERT_NEXT(a_last_resets, in_accept && s_tlast,
		phase_q == hcbd_pkg::PH_LEAD && !stop_q && !crp_q && size_q == '0,
		"decoder not reset after last byte")

endmodule
